// ===== design/sukey_pkg.sv =====
package sukey_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int WORD_W          = 64;
  localparam int KEY_WORDS       = 4;
  localparam int KEY_W           = WORD_W * KEY_WORDS;
  localparam int SLOT_W          = 6;
  localparam int COUNT_W         = 7;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_FULL = 2'd2,
    STATUS_DUP  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [0:0]        mode;
    logic [WORD_W-1:0] key_word0;
    logic [WORD_W-1:0] key_word1;
    logic [WORD_W-1:0] key_word2;
    logic [WORD_W-1:0] key_word3;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

// ===== design/sukey_ram.sv =====
module sukey_ram #(
  parameter int DEPTH = sukey_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = 6
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [sukey_pkg::KEY_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [sukey_pkg::KEY_W-1:0] rdata
);

  logic [sukey_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sukey_seq.sv =====
module sukey_seq #(
  parameter int MAX_ENTRIES = sukey_pkg::MAX_ENTRIES_DEF,
  parameter int IW          = 6,
  parameter int CW          = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  sukey_pkg::req_t             req,
  output logic                        we,
  output logic [IW-1:0]               waddr,
  output logic [sukey_pkg::KEY_W-1:0] wdata,
  output logic [IW-1:0]               raddr,
  input  logic [sukey_pkg::KEY_W-1:0] rdata,
  output logic                        done_valid,
  input  logic                        done_ready,
  output sukey_pkg::rsp_t             done_rsp
);

  sukey_pkg::state_t           state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [IW-1:0]               ptr, ptr_next;
  logic [IW-1:0]               pos, pos_next;
  logic [sukey_pkg::KEY_W-1:0] key, key_next;
  sukey_pkg::rsp_t             rsp, rsp_next;
  logic [sukey_pkg::KEY_W-1:0] req_key;

  assign req_key  = {req.key_word0, req.key_word1, req.key_word2, req.key_word3};
  assign done_rsp = rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sukey_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    pos <= pos_next;
    key <= key_next;
    rsp <= rsp_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    pos_next   = pos;
    key_next   = key;
    rsp_next   = rsp;
    raddr      = ptr;
    we         = 1'b0;
    waddr      = pos;
    wdata      = key;
    req_ready  = (state == sukey_pkg::ST_IDLE);
    done_valid = (state == sukey_pkg::ST_DONE);
    case (state)
      sukey_pkg::ST_IDLE: begin
        if (req_valid) begin
          key_next = req_key;
          rsp_next.slot        = '0;
          rsp_next.entry_count = sukey_pkg::COUNT_W'(count);
          if (req.mode == sukey_pkg::MODE_CLEAR) begin
            count_next           = '0;
            rsp_next.status      = sukey_pkg::STATUS_OK;
            rsp_next.entry_count = '0;
            state_next           = sukey_pkg::ST_DONE;
          end else if (req_key == '0) begin
            rsp_next.status = sukey_pkg::STATUS_ZERO;
            state_next      = sukey_pkg::ST_DONE;
          end else if (count >= CW'(MAX_ENTRIES)) begin
            rsp_next.status = sukey_pkg::STATUS_FULL;
            state_next      = sukey_pkg::ST_DONE;
          end else if (count == '0) begin
            pos_next   = '0;
            state_next = sukey_pkg::ST_WRITE;
          end else begin
            ptr_next   = '0;
            raddr      = '0;
            state_next = sukey_pkg::ST_SEARCH;
          end
        end
      end
      sukey_pkg::ST_SEARCH: begin
        if (key == rdata) begin
          rsp_next.status = sukey_pkg::STATUS_DUP;
          state_next      = sukey_pkg::ST_DONE;
        end else if (key < rdata) begin
          pos_next   = ptr;
          ptr_next   = IW'(count - CW'(1));
          raddr      = IW'(count - CW'(1));
          state_next = sukey_pkg::ST_SHIFT;
        end else if (CW'(ptr) + CW'(1) == count) begin
          pos_next   = IW'(count);
          state_next = sukey_pkg::ST_WRITE;
        end else begin
          ptr_next = ptr + IW'(1);
          raddr    = ptr + IW'(1);
        end
      end
      sukey_pkg::ST_SHIFT: begin
        we    = 1'b1;
        waddr = ptr + IW'(1);
        wdata = rdata;
        if (ptr == pos) begin
          state_next = sukey_pkg::ST_WRITE;
        end else begin
          ptr_next = ptr - IW'(1);
          raddr    = ptr - IW'(1);
        end
      end
      sukey_pkg::ST_WRITE: begin
        we                   = 1'b1;
        waddr                = pos;
        wdata                = key;
        count_next           = count + CW'(1);
        rsp_next.status      = sukey_pkg::STATUS_OK;
        rsp_next.slot        = sukey_pkg::SLOT_W'(pos);
        rsp_next.entry_count = sukey_pkg::COUNT_W'(count + CW'(1));
        state_next           = sukey_pkg::ST_DONE;
      end
      sukey_pkg::ST_DONE: begin
        if (done_ready) begin
          state_next = sukey_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sukey_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/sorted_unique_key_insert.sv =====
// A clear, a zero key or a full-table reject goes straight from acceptance to ST_DONE and
// then into the output register. Other inserts into a non-empty table read one stored key
// per cycle until the key's position or a duplicate turns up, move each larger entry up one
// slot, then write the new key. One item is in work at a time; reset clears the count and
// control state, not stored keys.
module sorted_unique_key_insert #(
  parameter int MAX_ENTRIES = sukey_pkg::MAX_ENTRIES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sukey_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output sukey_pkg::rsp_t rsp
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic                        we;
  logic [IW-1:0]               waddr;
  logic [IW-1:0]               raddr;
  logic [sukey_pkg::KEY_W-1:0] wdata;
  logic [sukey_pkg::KEY_W-1:0] rdata;
  logic                        done_valid;
  logic                        done_ready;
  sukey_pkg::rsp_t             done_rsp;

  sukey_ram #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sukey_seq #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .IW          (IW),
    .CW          (CW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .rdata      (rdata),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_rsp   (done_rsp)
  );

  assign done_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_ready) begin
      rsp_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      rsp <= done_rsp;
    end
  end

  a_reject_slot_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != sukey_pkg::STATUS_OK |-> rsp.slot == '0)
    else $error("Rejected beat carries a nonzero slot.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("A new beat was taken while an item was still in work.");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    done_valid && done_ready |=> rsp_valid)
    else $error("A finished result did not reach the output register.");

endmodule

// ===== bench/sorted_unique_key_insert_tb.sv =====
`timescale 1ns / 1ps

module sorted_unique_key_insert_tb;
  import sukey_pkg::*;

  localparam int TABLE_DEPTH    = MAX_ENTRIES_DEF;
  localparam int ITEM_TARGET    = 1600;
  localparam int DRAIN_CYCLES   = 2 * TABLE_DEPTH + 20;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic [KEY_W-1:0] model_keys [TABLE_DEPTH];
  int               model_count = 0;
  int               peak_count  = 0;

  req_t             pending_reqs[$];
  rsp_t             expected_rsps[$];
  logic [KEY_W-1:0] episode_keys[$];

  int reqs_taken   = 0;
  int rsps_taken   = 0;
  int errors       = 0;
  int clears_seen  = 0;
  int status_seen[4] = '{0, 0, 0, 0};
  int send_gap     = 0;
  int recv_gap     = 0;
  int hold_left    = 0;
  int next_hold    = 200;
  int steady_left  = 0;
  int quiet_cycles = 0;
  logic steady     = 1'b0;

  sorted_unique_key_insert #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t             res;
    logic [KEY_W-1:0] key;
    int               pos;
    res = '0;
    key = {r.key_word0, r.key_word1, r.key_word2, r.key_word3};
    if (r.mode == MODE_CLEAR) begin
      model_count = 0;
      res.status  = STATUS_OK;
      return res;
    end
    res.entry_count = COUNT_W'(model_count);
    if (key == '0) begin
      res.status = STATUS_ZERO;
      return res;
    end
    if (model_count >= TABLE_DEPTH) begin
      res.status = STATUS_FULL;
      return res;
    end
    pos = 0;
    while (pos < model_count && model_keys[pos] < key) pos++;
    if (pos < model_count && model_keys[pos] == key) begin
      res.status = STATUS_DUP;
      return res;
    end
    for (int i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
    model_keys[pos] = key;
    model_count++;
    res.status      = STATUS_OK;
    res.slot        = SLOT_W'(pos);
    res.entry_count = COUNT_W'(model_count);
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] shaped_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 3));
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    return {shaped_word(), shaped_word(), shaped_word(), shaped_word()};
  endfunction

  // Changes one word of a stored key so that comparisons run deep into the key.
  function automatic logic [KEY_W-1:0] near_key(logic [KEY_W-1:0] k);
    int          w;
    logic [63:0] word;
    w    = $urandom_range(0, 3);
    word = k[KEY_W-1-64*w -: 64];
    case ($urandom_range(0, 2))
      0:       word = word + 64'd1;
      1:       word = word - 64'd1;
      default: word = shaped_word();
    endcase
    k[KEY_W-1-64*w -: 64] = word;
    return k;
  endfunction

  task automatic push_req(mode_t m, logic [KEY_W-1:0] key);
    req_t r;
    r.mode = m;
    {r.key_word0, r.key_word1, r.key_word2, r.key_word3} = key;
    pending_reqs.push_back(r);
  endtask

  task automatic push_insert(logic [KEY_W-1:0] key);
    push_req(MODE_INSERT, key);
  endtask

  task automatic push_clear();
    push_req(MODE_CLEAR, {rand_word(), rand_word(), rand_word(), rand_word()});
    episode_keys.delete();
  endtask

  task automatic note_mismatch(string what, int want, int got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : drive_req
    rsp_t want;
    if (rst) begin
      req_valid <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (req_valid && req_ready) begin
        want = apply_table_op(req);
        expected_rsps.push_back(want);
        reqs_taken <= reqs_taken + 1;
        if (req.mode == MODE_CLEAR) clears_seen++;
        else status_seen[want.status]++;
        if (model_count > peak_count) peak_count = model_count;
      end
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          req_valid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          req       <= pending_reqs.pop_front();
          req_valid <= 1'b1;
          send_gap  <= idle_gap();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    int   stall;
    rsp_t want;
    if (rst) begin
      rsp_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      stall = recv_gap;
      if (rsp_valid && rsp_ready) begin
        rsps_taken <= rsps_taken + 1;
        stall = idle_gap();
        if (expected_rsps.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected: status %0d slot %0d count %0d",
                   $time, rsp.status, rsp.slot, rsp.entry_count);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.status !== want.status) note_mismatch("status", want.status, rsp.status);
          if (rsp.slot !== want.slot) note_mismatch("slot", want.slot, rsp.slot);
          if (rsp.entry_count !== want.entry_count)
            note_mismatch("entry_count", want.entry_count, rsp.entry_count);
        end
      end
      if (hold_left > 0 || stall > 0) begin
        rsp_ready <= 1'b0;
        recv_gap  <= (stall > 0) ? stall - 1 : 0;
      end else begin
        rsp_ready <= 1'b1;
        recv_gap  <= 0;
      end
    end
  end

  // Long receiver hold-offs fill the block and back up the input, and steady
  // stretches run both sides without idling.
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      next_hold   <= 200;
      steady      <= 1'b0;
      steady_left <= 0;
    end else begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (reqs_taken >= next_hold) begin
        hold_left <= HOLD_CYCLES;
        next_hold <= next_hold + 600;
      end
      if (steady_left > 0) begin
        steady_left <= steady_left - 1;
      end else begin
        steady      <= ($urandom_range(0, 2) == 0);
        steady_left <= $urandom_range(50, 300);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               total;
    int               flavor;
    int               len;
    int               pick;
    logic [63:0]      prefix;
    logic [KEY_W-1:0] key;

    push_clear();
    push_insert('0);
    push_insert('1);
    push_insert(KEY_W'(1));
    push_insert('1);
    push_insert({64'h8000_0000_0000_0000, 192'd0});
    push_insert({64'h7fff_ffff_ffff_ffff, {192{1'b1}}});
    push_insert({64'h8000_0000_0000_0000, 128'd0, 64'd1});
    push_insert({64'h8000_0000_0000_0000, 64'd0, 64'd1, 64'd0});
    push_insert({64'h8000_0000_0000_0000, 64'd1, 128'd0});
    push_insert('0);
    push_insert(KEY_W'(1));
    push_insert({64'h8000_0000_0000_0000, 64'd0, 64'd1, 64'd0});
    push_clear();
    push_clear();
    push_insert({192'd0, 64'hffff_ffff_ffff_ffff});

    // Fill in descending order so every insert shifts the whole table, then
    // probe the full table with a zero key, a duplicate and new keys.
    push_clear();
    prefix = rand_word();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      key = {prefix, 64'(TABLE_DEPTH - i), rand_word(), rand_word()};
      push_insert(key);
      episode_keys.push_back(key);
    end
    push_insert('0);
    push_insert(episode_keys[7]);
    push_insert({prefix, 64'd0, rand_word(), rand_word()});
    push_insert('1);

    while (pending_reqs.size() < ITEM_TARGET) begin
      flavor = $urandom_range(0, 3);
      if ($urandom_range(0, 3) != 0) push_clear();
      prefix = rand_word();
      len    = (flavor == 3) ? $urandom_range(80, 90) : $urandom_range(4, 50);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
          push_insert('0);
        end else if (pick < 12 && episode_keys.size() > 0) begin
          push_insert(episode_keys[$urandom_range(0, episode_keys.size() - 1)]);
        end else if (pick < 13 && flavor == 0) begin
          push_clear();
        end else begin
          if (flavor == 1)
            key = {prefix, 64'(i), rand_word(), rand_word()};
          else if (flavor == 2)
            key = {prefix, 64'(1000 - i), rand_word(), rand_word()};
          else if (pick < 50 && episode_keys.size() > 0)
            key = near_key(episode_keys[$urandom_range(0, episode_keys.size() - 1)]);
          else
            key = fresh_key();
          push_insert(key);
          episode_keys.push_back(key);
        end
      end
    end
    total = pending_reqs.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (reqs_taken < total || expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items: %0d inserted, %0d zero keys, %0d on a full table, %0d duplicates, %0d clears.",
             total, status_seen[STATUS_OK], status_seen[STATUS_ZERO],
             status_seen[STATUS_FULL], status_seen[STATUS_DUP], clears_seen);
    $display("Largest table size reached: %0d of %0d; %0d result beats checked, %0d errors.",
             peak_count, TABLE_DEPTH, rsps_taken, errors);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
